/* rtl/core/dmwtc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmwtc_pkg: shared types and constants of the write-through cache
// Beat formats of the request and response channels, the access codes and the
// default cache geometry.
// ----------------------------------------------------------------------------
package dmwtc_pkg;

	localparam int INDEX_WIDTH_DEF  = 6;
	localparam int OFFSET_WIDTH_DEF = 3;
	localparam int BLOCK_BYTES_DEF  = 8;

	localparam int ADDR_WIDTH  = 32;
	localparam int BLOCK_WIDTH = 64;
	localparam int CNT_WIDTH   = 32;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic                   opcode;
		logic [ADDR_WIDTH-1:0]  address;
		logic [7:0]             write_byte;
		logic [BLOCK_WIDTH-1:0] fill_block;
	} req_t;

	typedef struct packed {
		logic [CNT_WIDTH-1:0] read_hit_count;
		logic [CNT_WIDTH-1:0] read_miss_count;
		logic [CNT_WIDTH-1:0] write_hit_count;
		logic [CNT_WIDTH-1:0] write_miss_count;
	} counts_t;

	typedef struct packed {
		logic                  hit;
		logic [7:0]            read_byte;
		logic                  mem_write_en;
		logic [ADDR_WIDTH-1:0] mem_write_addr;
		logic [7:0]            mem_write_byte;
		logic [CNT_WIDTH-1:0]  read_hit_count;
		logic [CNT_WIDTH-1:0]  read_miss_count;
		logic [CNT_WIDTH-1:0]  write_hit_count;
		logic [CNT_WIDTH-1:0]  write_miss_count;
	} rsp_t;

endpackage
`default_nettype wire

/* rtl/core/direct_mapped_write_through_cache.sv */
`timescale 1ns / 1ps
`default_nettype none
// The cache takes one byte access per clock, held off by req_stall while the
// lookup stage is full and the response register is stalled. An accepted
// request reads the line memory into the lookup stage, which then writes the
// updated line back and loads the response register. Throughput is set by
// the single read and single write port of the line memory, one of each per
// cycle; a line updated by one access is forwarded to the next one when both
// touch the same index. Valid bits are flops cleared by reset, so the cache
// is usable right after reset with no clearing pass.
// ----------------------------------------------------------------------------
// direct_mapped_write_through_cache: direct-mapped, write-allocate,
// write-through byte cache
// Lookup, refill, byte read or write, write-through and hit/miss statistics.
// ----------------------------------------------------------------------------
module direct_mapped_write_through_cache #(
	parameter int INDEX_WIDTH  = dmwtc_pkg::INDEX_WIDTH_DEF,
	parameter int OFFSET_WIDTH = dmwtc_pkg::OFFSET_WIDTH_DEF,
	parameter int BLOCK_BYTES  = dmwtc_pkg::BLOCK_BYTES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output      logic            req_stall,
	input  wire dmwtc_pkg::req_t req,
	output      logic            rsp_valid,
	input  wire logic            rsp_stall,
	output      dmwtc_pkg::rsp_t rsp
);

	localparam int TAG_WIDTH = dmwtc_pkg::ADDR_WIDTH - INDEX_WIDTH - OFFSET_WIDTH;
	localparam logic [dmwtc_pkg::ADDR_WIDTH-1:0] OFF_MASK =
		(32'd1 << OFFSET_WIDTH) - 32'd1;
	localparam logic [dmwtc_pkg::BLOCK_WIDTH-1:0] FILL_MASK = (BLOCK_BYTES >= 8) ?
		{dmwtc_pkg::BLOCK_WIDTH{1'b1}} : ((64'd1 << (8 * BLOCK_BYTES)) - 64'd1);
	localparam logic [3:0] BLOCK_BYTES_W = 4'(BLOCK_BYTES);

	logic                               accept;
	logic                               out_free;
	logic                               s1_adv;
	logic                               valid_s1;
	dmwtc_pkg::req_t                    req_s1;
	logic                               fwd_s1;
	logic [TAG_WIDTH-1:0]               fwd_tag_s1;
	logic [dmwtc_pkg::BLOCK_WIDTH-1:0]  fwd_data_s1;

	logic [INDEX_WIDTH-1:0]             in_idx;
	logic [INDEX_WIDTH-1:0]             idx_s1;
	logic [TAG_WIDTH-1:0]               tag_s1;
	logic [2:0]                         off_s1;
	logic [5:0]                         bit_s1;
	logic                               in_block;
	logic                               is_write;

	logic                               st_valid;
	logic [TAG_WIDTH-1:0]               st_tag;
	logic [dmwtc_pkg::BLOCK_WIDTH-1:0]  st_data;

	logic                               cur_valid;
	logic [TAG_WIDTH-1:0]               cur_tag;
	logic [dmwtc_pkg::BLOCK_WIDTH-1:0]  cur_data;
	logic                               hit;
	logic [dmwtc_pkg::BLOCK_WIDTH-1:0]  base_data;
	logic [dmwtc_pkg::BLOCK_WIDTH-1:0]  new_data;
	logic [7:0]                         rd_byte;

	dmwtc_pkg::counts_t                 cnt_next;
	dmwtc_pkg::rsp_t                    rsp_d;
	logic                               rsp_valid_q;
	dmwtc_pkg::rsp_t                    rsp_q;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign s1_adv    = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;
	assign accept    = req_valid && !req_stall;

	assign in_idx = INDEX_WIDTH'(req.address >> OFFSET_WIDTH);
	assign idx_s1 = INDEX_WIDTH'(req_s1.address >> OFFSET_WIDTH);
	assign tag_s1 = TAG_WIDTH'(req_s1.address >> (OFFSET_WIDTH + INDEX_WIDTH));
	assign off_s1 = 3'(req_s1.address & OFF_MASK);
	assign bit_s1 = {off_s1, 3'b000};
	assign in_block = {1'b0, off_s1} < BLOCK_BYTES_W;
	assign is_write = (req_s1.opcode == dmwtc_pkg::OP_WRITE);

	dmwtc_line_store #(
		.INDEX_WIDTH  (INDEX_WIDTH),
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (accept),
		.rd_idx     (in_idx),
		.rd_valid_q (st_valid),
		.rd_tag_q   (st_tag),
		.rd_data_q  (st_data),
		.wr_en      (s1_adv),
		.wr_idx     (idx_s1),
		.wr_tag     (tag_s1),
		.wr_data    (new_data)
	);

	// The memory read of an access overlaps the write-back of the one ahead of
	// it, so a same-index pair takes the line from the forwarding register.
	assign cur_valid = fwd_s1 || st_valid;
	assign cur_tag   = fwd_s1 ? fwd_tag_s1 : st_tag;
	assign cur_data  = fwd_s1 ? fwd_data_s1 : st_data;
	assign hit       = cur_valid && (cur_tag == tag_s1);
	assign base_data = hit ? cur_data : (req_s1.fill_block & FILL_MASK);

	always_comb begin
		new_data = base_data;
		if (is_write && in_block) begin
			new_data[bit_s1 +: 8] = req_s1.write_byte;
		end
	end

	assign rd_byte = (!is_write && in_block) ? base_data[bit_s1 +: 8] : 8'd0;

	dmwtc_stats u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (s1_adv),
		.is_write (is_write),
		.hit      (hit),
		.cnt_next (cnt_next)
	);

	always_comb begin
		rsp_d.hit              = hit;
		rsp_d.read_byte        = rd_byte;
		rsp_d.mem_write_en     = is_write;
		rsp_d.mem_write_addr   = is_write ? req_s1.address : '0;
		rsp_d.mem_write_byte   = is_write ? req_s1.write_byte : 8'd0;
		rsp_d.read_hit_count   = cnt_next.read_hit_count;
		rsp_d.read_miss_count  = cnt_next.read_miss_count;
		rsp_d.write_hit_count  = cnt_next.write_hit_count;
		rsp_d.write_miss_count = cnt_next.write_miss_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= valid_s1 && (idx_s1 == in_idx);
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1      <= req;
			fwd_tag_s1  <= tag_s1;
			fwd_data_s1 <= new_data;
		end
		if (s1_adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

/* rtl/core/dmwtc_line_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmwtc_line_store: tag and data arrays with valid bits
// One registered read port and one write port. Valid bits sit in flops that
// reset clears; tag and data live in a memory without reset.
// ----------------------------------------------------------------------------
module dmwtc_line_store #(
	parameter int INDEX_WIDTH  = dmwtc_pkg::INDEX_WIDTH_DEF,
	parameter int OFFSET_WIDTH = dmwtc_pkg::OFFSET_WIDTH_DEF,
	localparam int TAG_WIDTH   = dmwtc_pkg::ADDR_WIDTH - INDEX_WIDTH - OFFSET_WIDTH,
	localparam int LINES       = 1 << INDEX_WIDTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               rd_en,
	input  wire logic [INDEX_WIDTH-1:0]             rd_idx,
	output      logic                               rd_valid_q,
	output      logic [TAG_WIDTH-1:0]               rd_tag_q,
	output      logic [dmwtc_pkg::BLOCK_WIDTH-1:0]  rd_data_q,
	input  wire logic                               wr_en,
	input  wire logic [INDEX_WIDTH-1:0]             wr_idx,
	input  wire logic [TAG_WIDTH-1:0]               wr_tag,
	input  wire logic [dmwtc_pkg::BLOCK_WIDTH-1:0]  wr_data
);

	logic [LINES-1:0]                      valid_q;
	logic [TAG_WIDTH-1:0]                  tag_mem  [LINES];
	logic [dmwtc_pkg::BLOCK_WIDTH-1:0]     data_mem [LINES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_mem[wr_idx]  <= wr_tag;
			data_mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_tag_q  <= tag_mem[rd_idx];
			rd_data_q <= data_mem[rd_idx];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/dmwtc_stats.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmwtc_stats: hit and miss counters
// Four wrapping counters; the outputs show the values after the access that
// is being retired.
// ----------------------------------------------------------------------------
module dmwtc_stats (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               upd,
	input  wire logic               is_write,
	input  wire logic               hit,
	output      dmwtc_pkg::counts_t cnt_next
);

	dmwtc_pkg::counts_t cnt_q;

	always_comb begin
		cnt_next = cnt_q;
		if (is_write) begin
			if (hit) begin
				cnt_next.write_hit_count = cnt_q.write_hit_count + 1'b1;
			end else begin
				cnt_next.write_miss_count = cnt_q.write_miss_count + 1'b1;
			end
		end else begin
			if (hit) begin
				cnt_next.read_hit_count = cnt_q.read_hit_count + 1'b1;
			end else begin
				cnt_next.read_miss_count = cnt_q.read_miss_count + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (upd) begin
			cnt_q <= cnt_next;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/dmwtc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmwtc_checker: port-level checks of the write-through cache
// Watches the response channel and the statistics it carries.
// ----------------------------------------------------------------------------
module dmwtc_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            req_stall,
	input wire logic            rsp_valid,
	input wire logic            rsp_stall,
	input wire dmwtc_pkg::rsp_t rsp
);

	logic                           rsp_fire;
	logic [dmwtc_pkg::CNT_WIDTH-1:0] total;

	assign rsp_fire = rsp_valid && !rsp_stall;
	assign total = rsp.read_hit_count + rsp.read_miss_count
		+ rsp.write_hit_count + rsp.write_miss_count;

	// A response that is held back stays as it was.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// A read beat carries no write-through.
	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.mem_write_en |->
			rsp.mem_write_addr == '0 && rsp.mem_write_byte == 8'd0)
		else $error("write-through fields set on a read");

	// A write beat returns no read data.
	a_write_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.mem_write_en |-> rsp.read_byte == 8'd0)
		else $error("read data on a write");

	// Each beat counts exactly one access more than the beat before it.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_fire ##1 rsp_valid |-> total == $past(total) + 1'b1)
		else $error("statistics did not advance by one access");

	// A request is never held off while the lookup stage is free to drain.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a stalled response");

endmodule

bind direct_mapped_write_through_cache dmwtc_checker u_dmwtc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire
